### rtl/core/dvmb_pkg.sv
`timescale 1ns / 1ps

package dvmb_pkg;

  // sequence counts and fixed frame layout
  localparam int PAL_SEQUENCES    = 12;
  localparam int NTSC_SEQUENCES   = 10;
  localparam int NTSC_MAX_SEQ     = NTSC_SEQUENCES - 1;
  localparam int NTSC_RIGHT_EDGE  = 22 * 4;
  localparam int DIF_PER_SEQUENCE = 150;
  localparam int DIF_VIDEO_BASE   = 7;
  localparam int MAX_SLOT         = 4;

  // reciprocal multipliers for the constant divisions
  localparam int DIV3_MUL   = 11;  // seg / 3 == (seg * 11) >> 5 for seg < 32
  localparam int DIV3_SHIFT = 5;
  localparam int DIV6_MUL   = 43;  // n / 6 == (n * 43) >> 8 for n < 64
  localparam int DIV6_SHIFT = 8;

  // field widths
  localparam int SEQ_W  = 4;
  localparam int SEG_W  = 5;
  localparam int SLOT_W = 3;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 3;
  localparam int XY_W   = 7;
  localparam int DIF_W  = 11;

  // vertical superblock map per slot
  function automatic logic [3:0] vert_map(input logic [SLOT_W-1:0] slot);
    logic [3:0] v;
    case (slot)
      3'd0:    v = 4'd2;
      3'd1:    v = 4'd6;
      3'd2:    v = 4'd8;
      3'd3:    v = 4'd0;
      default: v = 4'd4;
    endcase
    return v;
  endfunction

  // horizontal superblock map per slot
  function automatic logic [COL_W-1:0] horz_map(input logic [SLOT_W-1:0] slot);
    logic [COL_W-1:0] h;
    case (slot)
      3'd0:    h = 3'd2;
      3'd1:    h = 3'd1;
      3'd2:    h = 3'd3;
      3'd3:    h = 3'd0;
      default: h = 3'd4;
    endcase
    return h;
  endfunction

  // 4:1:1 column offset per superblock column
  function automatic logic [4:0] off_411(input logic [COL_W-1:0] col);
    logic [4:0] o;
    case (col)
      3'd0:    o = 5'd0;
      3'd1:    o = 5'd4;
      3'd2:    o = 5'd9;
      3'd3:    o = 5'd13;
      default: o = 5'd18;
    endcase
    return o;
  endfunction

  // 4:2:0 column offset per superblock column
  function automatic logic [5:0] off_420(input logic [COL_W-1:0] col);
    logic [5:0] o;
    case (col)
      3'd0:    o = 6'd0;
      3'd1:    o = 6'd9;
      3'd2:    o = 6'd18;
      3'd3:    o = 6'd27;
      default: o = 6'd36;
    endcase
    return o;
  endfunction

endpackage

### rtl/core/dv_macroblock_placement.sv
`timescale 1ns / 1ps

// DV DIF macroblock placement: maps (sequence, segment, slot) to picture place.
// input stream in_*: one item per macroblock, taken when in_tvalid && in_tready.
// result stream out_*: one item per input item, in the same order.
// cfg_wr_en / cfg_wr_data write pal_mode (1 = PAL 4:2:0, 0 = NTSC 4:1:1);
// change it only while no item is in flight.
// path: an accepted item passes the input register, then the result register,
// before it shows on out_tvalid, if the result side is not stalled.
// throughput: one item per cycle unless stalled; all address math sits between
// the two registers as small constant multiplies, adds and table lookups.
// stall: a waiting result holds steady on out_*; one more item is still
// taken into the input register, then in_tready drops until the result
// register frees up.
// reset (rst_n low at a clock edge): both stages empty, pal_mode back to 1.
module dv_macroblock_placement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sequence_number[3:0], segment_number[8:4],
                                  // macroblock_slot[11:9], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // superblock_row[3:0], superblock_col[6:4],
                                  // left_x[13:7], top_y[20:14],
                                  // dif_block_index[31:21]
  output logic        out_tuser   // sequence_invalid
);

  localparam int SEQ_W  = dvmb_pkg::SEQ_W;
  localparam int SEG_W  = dvmb_pkg::SEG_W;
  localparam int SLOT_W = dvmb_pkg::SLOT_W;
  localparam int ROW_W  = dvmb_pkg::ROW_W;
  localparam int COL_W  = dvmb_pkg::COL_W;
  localparam int XY_W   = dvmb_pkg::XY_W;
  localparam int DIF_W  = dvmb_pkg::DIF_W;

  logic              pal_mode_r;
  logic              in_valid_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [SEG_W-1:0]  seg_r;
  logic [SLOT_W-1:0] slot_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;
  logic              advance;
  logic              in_take;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      pal_mode_r <= cfg_wr_data;
    end
  end

  // handshake: result register moves when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      seq_r  <= in_tdata[SEQ_W-1:0];
      seg_r  <= in_tdata[SEQ_W+SEG_W-1:SEQ_W];
      slot_r <= in_tdata[SEQ_W+SEG_W+SLOT_W-1:SEQ_W+SEG_W];
    end
  end

  // placement math
  logic [SLOT_W-1:0] slot_c;
  logic [4:0]        row_sum;
  logic [ROW_W-1:0]  sb_row;
  logic [COL_W-1:0]  sb_col;
  logic [8:0]        prod3;
  logic [3:0]        d3;
  logic [1:0]        m3;
  logic [1:0]        r420;
  logic [5:0]        c420;
  logic [5:0]        rr420;
  logic [XY_W-1:0]   x420, y420;
  logic [5:0]        n411;
  logic [10:0]       prod6;
  logic [2:0]        d6;
  logic [2:0]        m6;
  logic [2:0]        r411;
  logic [4:0]        c411;
  logic [XY_W-1:0]   x411;
  logic [7:0]        row6;
  logic [7:0]        y411;
  logic [11:0]       dif_sum;
  logic [XY_W-1:0]   left_x, top_y;
  logic              seq_bad;

  always_comb begin
    // out-of-range slot acts as the last slot
    slot_c = (slot_r > SLOT_W'(dvmb_pkg::MAX_SLOT)) ? SLOT_W'(dvmb_pkg::MAX_SLOT) : slot_r;

    // superblock row: at most 23 before the reduction
    row_sum = 5'(seq_r) + 5'(dvmb_pkg::vert_map(slot_c));
    if (pal_mode_r) begin
      sb_row = (row_sum >= 5'(dvmb_pkg::PAL_SEQUENCES))
             ? ROW_W'(row_sum - 5'(dvmb_pkg::PAL_SEQUENCES)) : ROW_W'(row_sum);
    end else if (row_sum >= 5'(2 * dvmb_pkg::NTSC_SEQUENCES)) begin
      sb_row = ROW_W'(row_sum - 5'(2 * dvmb_pkg::NTSC_SEQUENCES));
    end else if (row_sum >= 5'(dvmb_pkg::NTSC_SEQUENCES)) begin
      sb_row = ROW_W'(row_sum - 5'(dvmb_pkg::NTSC_SEQUENCES));
    end else begin
      sb_row = ROW_W'(row_sum);
    end
    sb_col = dvmb_pkg::horz_map(slot_c);

    // 4:2:0 zigzag, three macroblocks per column
    prod3 = 9'(seg_r) * 9'(dvmb_pkg::DIV3_MUL);
    d3    = 4'(prod3 >> dvmb_pkg::DIV3_SHIFT);
    m3    = 2'(5'(seg_r) - 5'(d3) * 5'd3);
    r420  = d3[0] ? 2'(2'd2 - m3) : m3;
    c420  = 6'(d3) + dvmb_pkg::off_420(sb_col);
    rr420 = 6'(r420) + 6'(sb_row) * 6'd3;
    x420  = XY_W'({c420, 1'b0});
    y420  = XY_W'({rr420, 1'b0});

    // 4:1:1 zigzag, six macroblocks per column, odd columns shifted by three
    n411  = sb_col[0] ? (6'(seg_r) + 6'd3) : 6'(seg_r);
    prod6 = 11'(n411) * 11'(dvmb_pkg::DIV6_MUL);
    d6    = 3'(prod6 >> dvmb_pkg::DIV6_SHIFT);
    m6    = 3'(n411 - 6'(d6) * 6'd6);
    r411  = d6[0] ? 3'(3'd5 - m6) : m6;
    c411  = 5'(d6) + dvmb_pkg::off_411(sb_col);
    x411  = XY_W'({c411, 2'b00});
    row6  = 8'(sb_row) * 8'd6;
    // rightmost column holds double-height macroblocks
    if (x411 < XY_W'(dvmb_pkg::NTSC_RIGHT_EDGE)) begin
      y411 = 8'(r411) + row6;
    end else begin
      y411 = 8'({r411, 1'b0}) + row6;
    end

    left_x = pal_mode_r ? x420 : x411;
    top_y  = pal_mode_r ? y420 : XY_W'(y411);

    // frame dif block index, wraps at the field width
    dif_sum = 12'(seq_r) * 12'(dvmb_pkg::DIF_PER_SEQUENCE)
            + 12'(dvmb_pkg::DIF_VIDEO_BASE)
            + 12'(seg_r) * 12'd5
            + 12'(d3)
            + 12'(slot_c);

    seq_bad = !pal_mode_r && (seq_r > SEQ_W'(dvmb_pkg::NTSC_MAX_SEQ));

    out_data_nxt = {DIF_W'(dif_sum), top_y, left_x, sb_col, sb_row};
    out_user_nxt = seq_bad;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/core/dvmb_checker.sv
`timescale 1ns / 1ps

module dvmb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset empties the pipe
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an accepted item has a result showing after the input and result registers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("result missing two cycles after accept");

  // flagged ntsc sequence still gets a row reduced modulo ten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3:0] <= 4'd9)
    else $error("flagged item with row above nine");

  // superblock column comes from a five entry map
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:4] <= 3'd4)
    else $error("superblock column out of range");

endmodule

bind dv_macroblock_placement dvmb_checker u_dvmb_checker (.*);

### tb/sv/dv_macroblock_placement_tb.sv
`timescale 1ns / 1ps

module dv_macroblock_placement_tb;

  // one placement result, packed as {out_tuser, out_tdata}
  typedef struct packed {
    logic                       inv;
    logic [dvmb_pkg::DIF_W-1:0] dif;
    logic [dvmb_pkg::XY_W-1:0]  y;
    logic [dvmb_pkg::XY_W-1:0]  x;
    logic [dvmb_pkg::COL_W-1:0] col;
    logic [dvmb_pkg::ROW_W-1:0] row;
  } placement_t;

  // one directed item, with a hand-written result where typed is set
  typedef struct packed {
    logic                        pal;
    logic [dvmb_pkg::SEQ_W-1:0]  seq;
    logic [dvmb_pkg::SEG_W-1:0]  seg;
    logic [dvmb_pkg::SLOT_W-1:0] slot;
    logic                        typed;
    placement_t                  res;
  } dir_row_t;

  // superblock maps and column offsets, indexed by slot or column
  localparam logic [4:0][3:0] ROW_STEP = {4'd4, 4'd0, 4'd8, 4'd6, 4'd2};
  localparam logic [4:0][2:0] COL_MAP  = {3'd4, 3'd0, 3'd3, 3'd1, 3'd2};
  localparam logic [4:0][4:0] OFS_411  = {5'd18, 5'd13, 5'd9, 5'd4, 5'd0};
  localparam logic [4:0][5:0] OFS_420  = {6'd36, 6'd27, 6'd18, 6'd9, 6'd0};
  localparam int RIGHT_EDGE = 88;
  localparam int DIR_ROWS   = 22;
  localparam int PIPE_LAT   = 2;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // sequence_number, segment_number, macroblock_slot
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // row, col, left_x, top_y, dif_block_index
  logic        out_tuser;          // sequence_invalid

  placement_t placement_q[$];
  logic       pal_shadow   = 1'b1;
  bit         idle_on      = 1'b1;
  int         hold_cycles  = 0;
  int         mismatch_cnt = 0;

  // directed items: corners, slots above four, out-of-range sequences and segments
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b1, 4'd0,  5'd0,  3'd0, 1'b1, '{1'b0, 11'd7,    7'd12, 7'd36, 3'd2, 4'd2}},
    '{1'b1, 4'd11, 5'd26, 3'd4, 1'b1, '{1'b0, 11'd1799, 7'd22, 7'd88, 3'd4, 4'd3}},
    '{1'b1, 4'd15, 5'd31, 3'd7, 1'b1, '{1'b0, 11'd378,  7'd44, 7'd92, 3'd4, 4'd7}},
    '{1'b1, 4'd5,  5'd13, 3'd1, 1'b0, '0},
    '{1'b1, 4'd3,  5'd7,  3'd2, 1'b0, '0},
    '{1'b1, 4'd8,  5'd20, 3'd3, 1'b0, '0},
    '{1'b1, 4'd12, 5'd4,  3'd5, 1'b0, '0},
    '{1'b1, 4'd14, 5'd27, 3'd6, 1'b0, '0},
    '{1'b1, 4'd9,  5'd2,  3'd4, 1'b0, '0},
    '{1'b0, 4'd0,  5'd0,  3'd0, 1'b1, '{1'b0, 11'd7,    7'd12, 7'd36, 3'd2, 4'd2}},
    '{1'b0, 4'd10, 5'd0,  3'd3, 1'b1, '{1'b1, 11'd1510, 7'd0,  7'd0,  3'd0, 4'd0}},
    '{1'b0, 4'd15, 5'd31, 3'd7, 1'b1, '{1'b1, 11'd378,  7'd62, 7'd92, 3'd4, 4'd9}},
    '{1'b0, 4'd9,  5'd26, 3'd4, 1'b0, '0},
    '{1'b0, 4'd4,  5'd24, 3'd4, 1'b0, '0},
    '{1'b0, 4'd7,  5'd25, 3'd4, 1'b0, '0},
    '{1'b0, 4'd2,  5'd5,  3'd1, 1'b0, '0},
    '{1'b0, 4'd6,  5'd11, 3'd2, 1'b0, '0},
    '{1'b0, 4'd1,  5'd17, 3'd3, 1'b0, '0},
    '{1'b0, 4'd11, 5'd30, 3'd5, 1'b0, '0},
    '{1'b0, 4'd8,  5'd3,  3'd0, 1'b0, '0},
    '{1'b0, 4'd13, 5'd28, 3'd6, 1'b0, '0},
    '{1'b1, 4'd6,  5'd9,  3'd0, 1'b0, '0}
  };

  dv_macroblock_placement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // picture place and frame position of one macroblock
  function automatic placement_t place_macroblock(input logic pal, input logic [3:0] seq,
                                                  input logic [4:0] seg,
                                                  input logic [2:0] slot);
    placement_t p;
    int q, g, s, nseq, row, col, n, r, d, c, x, y, dif;
    q = int'(seq);
    g = int'(seg);
    s = (slot > 3'd4) ? 4 : int'(slot);
    nseq = pal ? 12 : 10;
    row = (q + int'(ROW_STEP[s[2:0]])) % nseq;
    col = int'(COL_MAP[s[2:0]]);
    if (pal) begin
      // 4:2:0 zigzag in steps of three rows
      r = g % 3;
      d = g / 3;
      if (d % 2 == 1) r = 2 - r;
      x = (d + int'(OFS_420[col[2:0]])) * 2;
      y = (r + row * 3) * 2;
    end else begin
      // 4:1:1 zigzag in steps of six rows, odd columns start half way
      n = (col % 2 == 1) ? g + 3 : g;
      r = n % 6;
      d = n / 6;
      if (d % 2 == 1) r = 5 - r;
      c = (d + int'(OFS_411[col[2:0]])) * 4;
      x = c;
      // rightmost column is laid out as 2x-tall blocks
      y = (c < RIGHT_EDGE) ? r + row * 6 : r * 2 + row * 6;
    end
    dif = q * 150 + 7 + 5 * g + g / 3 + s;
    p.row = row[dvmb_pkg::ROW_W-1:0];
    p.col = col[dvmb_pkg::COL_W-1:0];
    p.x   = x[dvmb_pkg::XY_W-1:0];
    p.y   = y[dvmb_pkg::XY_W-1:0];
    p.dif = dif[dvmb_pkg::DIF_W-1:0];
    p.inv = !pal && (q > 9);
    return p;
  endfunction

  // offer one item, optionally after a gap, and log what it should produce
  task automatic send_item(input logic [3:0] seq, input logic [4:0] seg,
                           input logic [2:0] slot, input logic typed,
                           input placement_t res);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, slot, seg, seq};
    do @(posedge clk); while (!in_tready);
    placement_q.push_back(typed ? res : place_macroblock(pal_shadow, seq, seg, slot));
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // switch PAL / NTSC while the pipe is empty
  task automatic set_mode(input logic pal);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pal;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pal_shadow  = pal;
  endtask

  // random items in one mode, mostly legal fields with some out of range
  task automatic run_random(input logic pal, input int count, input int quiet_from,
                            input int hold_at);
    logic [3:0] seq;
    logic [4:0] seg;
    logic [2:0] slot;
    set_mode(pal);
    for (int i = 0; i < count; i++) begin
      if (i >= quiet_from)
        idle_on = 1'b0;
      else if (i % 50 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if (i == hold_at)
        hold_cycles = 80;
      seq  = 4'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 15)
                                           : $urandom_range(0, pal ? 11 : 9));
      seg  = 5'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 31)
                                           : $urandom_range(0, 26));
      slot = 3'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 7)
                                           : $urandom_range(0, 4));
      send_item(seq, seg, slot, 1'b0, '0);
    end
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (placement_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        mismatch_cnt++;
      end else begin
        want = placement_q.pop_front();
        check_field("superblock_row", 32'(want.row), 32'(got.row));
        check_field("superblock_col", 32'(want.col), 32'(got.col));
        check_field("left_x", 32'(want.x), 32'(got.x));
        check_field("top_y", 32'(want.y), 32'(got.y));
        check_field("dif_block_index", 32'(want.dif), 32'(got.dif));
        check_field("sequence_invalid", 32'(want.inv), 32'(got.inv));
      end
    end
  end

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, first ones rely on the reset mode
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].pal != pal_shadow)
        set_mode(dir_tab[i].pal);
      send_item(dir_tab[i].seq, dir_tab[i].seg, dir_tab[i].slot, dir_tab[i].typed,
                dir_tab[i].res);
    end

    run_random(1'b0, 400, 400, -1);
    run_random(1'b1, 400, 400, 120);
    run_random(1'b0, 350, 350, -1);
    run_random(1'b1, 380, 230, -1);

    drain();
    if (mismatch_cnt == 0)
      $display("dv_macroblock_placement regression: pass");
    else
      $display("dv_macroblock_placement regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("dv_macroblock_placement regression: fail");
    $finish;
  end

endmodule

### dv_macroblock_placement.f
rtl/core/dvmb_pkg.sv
rtl/core/dv_macroblock_placement.sv
rtl/core/dvmb_checker.sv
tb/sv/dv_macroblock_placement_tb.sv
